// ----- hdl/fta_pkg.sv -----
`default_nettype none

package fta_pkg;

  // Result and angle accumulator widths
  localparam int ANGLE_WIDTH = 16;
  localparam int Z_WIDTH     = 32;

  // Fraction bits added below the coordinates before the rotations
  localparam int FRAC_GUARD  = 24;

  // Most rotation steps the angle table supports
  localparam int STEP_LIMIT  = 32;

  // Defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF  = 16;

  // Fixed angles in accumulator units (full turn / 2^32)
  localparam logic [Z_WIDTH-1:0] Z_HALF_TURN    = 32'h8000_0000;
  localparam logic [Z_WIDTH-1:0] Z_QUARTER_TURN = 32'h4000_0000;
  localparam logic [Z_WIDTH-1:0] Z_THREE_QUART  = 32'hC000_0000;
  localparam logic [Z_WIDTH-1:0] Z_ZERO         = 32'h0000_0000;
  localparam logic [Z_WIDTH-1:0] Z_ROUND_HALF   = 32'h0000_8000;

  typedef logic [Z_WIDTH-1:0] zang_t;

  // atan(2^-i) in units of full turn / 2^32
  localparam zang_t STEP_ANGLE [STEP_LIMIT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

// ----- hdl/full_turn_angle_of_vector.sv -----
// Vector angle over a full turn. Each item is a signed (x, y) pair; the result is its
// counter-clockwise angle from the positive x axis in units of full turn / 65536,
// from 0 up to just below one turn. A vector on the y axis gives a quarter turn
// (y positive) or three quarters (y negative); the zero vector gives 0. One item
// enters per clock while in_stall is low. A register folds the left half-plane,
// one pipeline stage follows per CORDIC rotation step, and the rounded angle goes
// into the output register. Every stage holds one item and moves up when the stage
// ahead is empty or moving, so gaps close up under a stalled output.
`default_nettype none

module full_turn_angle_of_vector
  import fta_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ITERATIONS  = ITERATIONS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [COORD_WIDTH-1:0]       in_x_in,
  input  wire  [COORD_WIDTH-1:0]       in_y_in,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [ANGLE_WIDTH-1:0]       out_angle
);

  localparam int NSTEP = (ITERATIONS > STEP_LIMIT) ? STEP_LIMIT : ITERATIONS;
  // Guarded coordinate width: sign, one bit for negating the most negative value,
  // one bit for the CORDIC gain
  localparam int W = COORD_WIDTH + FRAC_GUARD + 2;

  // Pipeline registers: index 0 is the folded input, index i+1 follows step i
  logic                v_r    [0:NSTEP];
  logic                spec_r [0:NSTEP];
  logic signed [W-1:0] x_r    [0:NSTEP];
  logic signed [W-1:0] y_r    [0:NSTEP];
  zang_t               z_r    [0:NSTEP];
  logic                rdy    [0:NSTEP];

  logic                   out_valid_r;
  logic [ANGLE_WIDTH-1:0] angle_r;
  logic                   out_open;

  // Input fold
  logic signed [W-1:0] x_ext, y_ext, x_fold, y_fold;
  logic                x_zero, x_neg, y_neg, y_zero;
  zang_t               z_fold;

  assign x_ext  = {{(W-COORD_WIDTH){in_x_in[COORD_WIDTH-1]}}, in_x_in};
  assign y_ext  = {{(W-COORD_WIDTH){in_y_in[COORD_WIDTH-1]}}, in_y_in};
  assign x_neg  = in_x_in[COORD_WIDTH-1];
  assign y_neg  = in_y_in[COORD_WIDTH-1];
  assign x_zero = (in_x_in == '0);
  assign y_zero = (in_y_in == '0);

  // Turn left half-plane vectors by a half turn; pick fixed angles on the y axis
  always_comb begin
    x_fold = x_neg ? -x_ext : x_ext;
    y_fold = x_neg ? -y_ext : y_ext;
    x_fold = x_fold <<< FRAC_GUARD;
    y_fold = y_fold <<< FRAC_GUARD;
    if (x_zero) begin
      if (y_zero) begin
        z_fold = Z_ZERO;
      end else if (y_neg) begin
        z_fold = Z_THREE_QUART;
      end else begin
        z_fold = Z_QUARTER_TURN;
      end
    end else if (x_neg) begin
      z_fold = Z_HALF_TURN;
    end else begin
      z_fold = Z_ZERO;
    end
  end

  // Stage moves when empty or when the stage ahead takes its item
  assign out_open   = !out_valid_r || !out_stall;
  assign rdy[NSTEP] = !v_r[NSTEP] || out_open;
  assign in_stall   = !rdy[0];

  // Load the folded input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      spec_r[0] <= x_zero;
      x_r[0]    <= x_fold;
      y_r[0]    <= y_fold;
      z_r[0]    <= z_fold;
    end
  end

  // One rotation step per stage
  genvar gi;
  generate
    for (gi = 0; gi < NSTEP; gi++) begin : g_step
      logic signed [W-1:0] dx, dy;
      logic signed [W-1:0] x_nxt, y_nxt;
      zang_t               z_nxt;

      assign rdy[gi] = !v_r[gi] || rdy[gi+1];
      assign dx = y_r[gi] >>> gi;
      assign dy = x_r[gi] >>> gi;

      // Rotate toward the x axis; hold the fixed angle of an axis vector
      always_comb begin
        if (!y_r[gi][W-1]) begin
          x_nxt = x_r[gi] + dx;
          y_nxt = y_r[gi] - dy;
          z_nxt = spec_r[gi] ? z_r[gi] : z_r[gi] + STEP_ANGLE[gi];
        end else begin
          x_nxt = x_r[gi] - dx;
          y_nxt = y_r[gi] + dy;
          z_nxt = spec_r[gi] ? z_r[gi] : z_r[gi] - STEP_ANGLE[gi];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gi+1] <= 1'b0;
        end else if (rdy[gi+1]) begin
          v_r[gi+1] <= v_r[gi];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[gi+1]) begin
          spec_r[gi+1] <= spec_r[gi];
          x_r[gi+1]    <= x_nxt;
          y_r[gi+1]    <= y_nxt;
          z_r[gi+1]    <= z_nxt;
        end
      end
    end
  endgenerate

  // Round the accumulator to the result width; wraps to 0 near a full turn
  zang_t z_round;
  assign z_round = z_r[NSTEP] + Z_ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= v_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      angle_r <= z_round[Z_WIDTH-1 -: ANGLE_WIDTH];
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

  // A blocked input stage keeps its item
  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !rdy[0]) |=> v_r[0])
    else $error("input stage dropped a blocked item");

  // A finished item reaches the output register once it is open
  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTEP] && out_open) |=> out_valid_r)
    else $error("last stage item not delivered to output register");

  // Input is only stalled while the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0])
    else $error("input stalled with empty first stage");

endmodule

`default_nettype wire

// ----- tb/sv/tb_full_turn_angle_of_vector.sv -----
`timescale 1ns / 1ps

module tb_full_turn_angle_of_vector;
  import fta_pkg::*;

  typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
  typedef logic [ANGLE_WIDTH-1:0] angle_t;

  localparam int RANDOM_VECTORS = 1600;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_OFF_LEN   = 200;
  localparam int PIPE_DEPTH     = ITERATIONS_DEF + 2;

  // Predicts the angle of each accepted vector and checks the results in order
  class angle_scoreboard;
    angle_t pending_angles[$];
    int     vectors_seen;
    int     angles_checked;
    int     mismatches;
    int     on_axis;
    int     left_half;

    // Fold the left half-plane, then run the vectoring rotations
    function angle_t predict_angle(coord_t x_c, coord_t y_c);
      longint xa;
      longint ya;
      longint dx;
      longint dy;
      zang_t  z;
      int     i;
      xa = longint'(x_c);
      ya = longint'(y_c);
      z  = Z_ZERO;
      if (xa == 0) begin
        if (ya > 0) return Z_QUARTER_TURN[Z_WIDTH-1 -: ANGLE_WIDTH];
        if (ya < 0) return Z_THREE_QUART[Z_WIDTH-1 -: ANGLE_WIDTH];
        return Z_ZERO[Z_WIDTH-1 -: ANGLE_WIDTH];
      end
      if (xa < 0) begin
        xa = -xa;
        ya = -ya;
        z  = Z_HALF_TURN;
      end
      xa = xa * (longint'(1) << FRAC_GUARD);
      ya = ya * (longint'(1) << FRAC_GUARD);
      for (i = 0; i < ITERATIONS_DEF && i < STEP_LIMIT; i++) begin
        dx = ya >>> i;
        dy = xa >>> i;
        if (ya >= 0) begin
          xa = xa + dx;
          ya = ya - dy;
          z  = z + STEP_ANGLE[i];
        end else begin
          xa = xa - dx;
          ya = ya + dy;
          z  = z - STEP_ANGLE[i];
        end
      end
      z = z + Z_ROUND_HALF;
      return z[Z_WIDTH-1 -: ANGLE_WIDTH];
    endfunction

    function void note_vector(coord_t x_c, coord_t y_c);
      vectors_seen++;
      if (x_c == 0) on_axis++;
      if (x_c < 0) left_half++;
      pending_angles.push_back(predict_angle(x_c, y_c));
    endfunction

    function void check_angle(angle_t got);
      angle_t want;
      angles_checked++;
      if (pending_angles.size() == 0) begin
        $error("angle %0d arrived with no vector pending", got);
        mismatches++;
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        $error("angle mismatch: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_angles.size();
    endfunction

    // Flag anything still waiting once the pipeline has drained
    function void close_out();
      if (pending_angles.size() != 0) begin
        $error("%0d angle results never arrived", pending_angles.size());
        mismatches++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  coord_t in_x_in = '0;
  coord_t in_y_in = '0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  angle_t out_angle;

  angle_scoreboard sb = new();
  int idle_cycles = 0;
  int held_cycles = 0;
  bit hold_off_done = 1'b0;

  full_turn_angle_of_vector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_angle (out_angle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Observe both handshakes and watch for a hung pipeline
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_vector(in_x_in, in_y_in);
      if (in_valid && in_stall) held_cycles++;
      if (out_valid && !out_stall) sb.check_angle(out_angle);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Mostly short gaps, some long ones, and stretches with none
  function int sender_gap(int k);
    int r;
    if ((k / 64) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Offer one item and hold it until it is taken
  task automatic send_vector(coord_t x_c, coord_t y_c, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_in  <= x_c;
    in_y_in  <= y_c;
    do @(posedge clk); while (in_stall);
  endtask

  function coord_t edge_coord();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Draw a vector from a mix of general and boundary-heavy regions
  task automatic pick_vector(output coord_t x_c, output coord_t y_c);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      x_c = coord_t'($urandom);
      y_c = coord_t'($urandom);
    end else if (r < 55) begin
      x_c = coord_t'($signed($urandom_range(0, 16)) - 8);
      y_c = coord_t'($signed($urandom_range(0, 16)) - 8);
    end else if (r < 65) begin
      x_c = '0;
      y_c = ($urandom_range(0, 7) == 0) ? coord_t'(0) : coord_t'($urandom);
    end else if (r < 72) begin
      x_c = coord_t'($urandom);
      y_c = '0;
    end else if (r < 80) begin
      // just below a full turn, where rounding wraps
      x_c = coord_t'($urandom_range(1, 32767));
      y_c = coord_t'(-$signed($urandom_range(1, 4)));
    end else if (r < 88) begin
      x_c = coord_t'($urandom);
      y_c = coord_t'(($urandom_range(0, 1) ? x_c : -x_c) + $signed($urandom_range(0, 4)) - 2);
    end else begin
      x_c = edge_coord();
      y_c = edge_coord();
    end
  endtask

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int r;
    wait (rst_n);
    forever begin
      if (!hold_off_done && sb.vectors_seen >= 300) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 88) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    coord_t dir_x [22] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
      16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
      16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'h3039, 16'hFFFE
    };
    coord_t dir_y [22] = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0001,
      16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hE57B, 16'h7FFF
    };
    coord_t vx;
    coord_t vy;
    int k;

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: axes, zero vector, extremes, wrap near a full turn
    for (k = 0; k < 22; k++) send_vector(dir_x[k], dir_y[k], $urandom_range(0, 2));

    // Random stream
    for (k = 0; k < RANDOM_VECTORS; k++) begin
      pick_vector(vx, vy);
      send_vector(vx, vy, sender_gap(k));
    end
    in_valid <= 1'b0;

    // Drain, then allow time for any stray result
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    sb.close_out();

    $display("Covered %0d vectors (%0d on the y axis, %0d in the left half-plane).",
             sb.vectors_seen, sb.on_axis, sb.left_half);
    $display("Checked %0d angles; input was held off for %0d cycles, %0d mismatches.",
             sb.angles_checked, held_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
